// ===== src/gda_pkg.sv =====
// Shared types, constants and calendar functions for the date-advance block.
// No dependencies; every other file imports this package.
package gda_pkg;

   localparam int unsigned YearWidth  = 14;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned DayWidth   = 5;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned DoyWidth   = 9;
   localparam int unsigned QuoWidth   = 8;
   localparam int unsigned RemWidth   = 7;

   localparam logic [YearWidth-1:0]  YearMax     = 14'd16383;
   localparam logic [MonthWidth-1:0] MonthJan    = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb    = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec    = 4'd12;
   localparam logic [DayWidth-1:0]   DayFirst    = 5'd1;
   localparam logic [RemWidth-1:0]   CenturyLast = 7'd99;
   localparam logic [RemWidth-1:0]   Century     = 7'd100;

   // floor(y / 100) == (y * DivMult) >> DivShift for every 14-bit year.
   localparam logic [12:0]  DivMult  = 13'd5243;
   localparam int unsigned  DivShift = 19;

   typedef struct packed {
      logic                  load;
      logic                  div;
      logic                  rem;
      logic                  check;
      logic                  step;
      logic                  push;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic bad_date;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [YearWidth-1:0]  start_year;
      logic [MonthWidth-1:0] start_month;
      logic [DayWidth-1:0]   start_day;
      logic [CountWidth-1:0] days_to_add;
   } req_type;

   typedef struct packed {
      logic [DoyWidth-1:0]   day_of_year;
      logic [YearWidth-1:0]  end_year;
      logic [MonthWidth-1:0] end_month;
      logic [DayWidth-1:0]   end_day;
      logic                  bad_date;
   } rsp_type;

   // Length of a month; zero for a code that is not a month.
   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] m,
                                                     input logic leap);
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
         4'd2:                                       month_len = leap ? 5'd29 : 5'd28;
         default:                                    month_len = 5'd0;
      endcase
   endfunction

   // Days in a common year before the first of the month.
   function automatic logic [DoyWidth-1:0] days_before(input logic [MonthWidth-1:0] m);
      case (m)
         4'd2:    days_before = 9'd31;
         4'd3:    days_before = 9'd59;
         4'd4:    days_before = 9'd90;
         4'd5:    days_before = 9'd120;
         4'd6:    days_before = 9'd151;
         4'd7:    days_before = 9'd181;
         4'd8:    days_before = 9'd212;
         4'd9:    days_before = 9'd243;
         4'd10:   days_before = 9'd273;
         4'd11:   days_before = 9'd304;
         4'd12:   days_before = 9'd334;
         default: days_before = 9'd0;
      endcase
   endfunction

endpackage

// ===== src/gda_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on gda_pkg for field widths.
interface gda_req_if import gda_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [YearWidth-1:0]  start_year;
   logic [MonthWidth-1:0] start_month;
   logic [DayWidth-1:0]   start_day;
   logic [CountWidth-1:0] days_to_add;

   modport source (output valid, start_year, start_month, start_day, days_to_add,
                   input ready);
   modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                   output ready);
endinterface

interface gda_rsp_if import gda_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DoyWidth-1:0]   day_of_year;
   logic [YearWidth-1:0]  end_year;
   logic [MonthWidth-1:0] end_month;
   logic [DayWidth-1:0]   end_day;
   logic                  bad_date;

   modport source (output valid, day_of_year, end_year, end_month, end_day, bad_date,
                   input ready);
   modport sink   (input valid, day_of_year, end_year, end_month, end_day, bad_date,
                   output ready);
endinterface

// ===== src/gda_ctrl.sv =====
// Sequencer for the date-advance block: load, year split, check, day steps, push.
// Depends on gda_pkg for the command and status structs.
module gda_ctrl import gda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_REM,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIV;
         ST_DIV:    state_in = ST_REM;
         ST_REM:    state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.bad_date || status.n_zero) state_in = ST_FINISH;
            else                                  state_in = ST_STEP;
         end
         ST_STEP:   if (status.n_one) state_in = ST_FINISH;
         ST_FINISH: if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd       = '0;
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.div   = (state_ff == ST_DIV);
      cmd.rem   = (state_ff == ST_REM);
      cmd.check = (state_ff == ST_CHECK);
      cmd.step  = (state_ff == ST_STEP);
      cmd.push  = (state_ff == ST_FINISH) && status.out_free;
   end

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.n_zero)
      else $error("day step issued with no days left");
`endif

endmodule

// ===== src/gda_dpath.sv =====
// Datapath of the date-advance block: date registers, century counters for the
// leap rule, day-of-year adder and the response register. Depends on gda_pkg.
module gda_dpath import gda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp
);

   logic [YearWidth-1:0]  year_ff;
   logic [MonthWidth-1:0] month_ff;
   logic [DayWidth-1:0]   day_ff;
   logic [CountWidth-1:0] count_ff;
   logic [QuoWidth-1:0]   quo_ff;
   logic [RemWidth-1:0]   rem_ff;
   logic [DoyWidth-1:0]   doy_ff;
   logic                  bad_ff;
   logic                  out_valid_ff;
   rsp_type               out_ff;

   logic [26:0]           prod;
   logic [YearWidth-1:0]  hundreds;
   logic                  leap;
   logic [DayWidth-1:0]   cur_len;
   logic                  bad_now;
   logic [DoyWidth-1:0]   doy_now;

   assign prod     = {13'd0, year_ff} * {14'd0, DivMult};
   assign hundreds = YearWidth'({6'd0, quo_ff} * {7'd0, Century});

   // Year divisible by 4, and not a century unless the century count is too.
   assign leap    = (year_ff[1:0] == 2'd0) && ((rem_ff != '0) || (quo_ff[1:0] == 2'd0));
   assign cur_len = month_len(month_ff, leap);
   assign bad_now = (day_ff == '0) || (day_ff > cur_len);
   assign doy_now = days_before(month_ff)
                  + {8'd0, leap && (month_ff > MonthFeb)}
                  + {4'd0, day_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff  <= req.start_year;
         month_ff <= req.start_month;
         day_ff   <= req.start_day;
         count_ff <= req.days_to_add;
      end
      if (cmd.div) quo_ff <= prod[DivShift +: QuoWidth];
      if (cmd.rem) rem_ff <= RemWidth'(year_ff - hundreds);
      if (cmd.check) begin
         bad_ff <= bad_now;
         doy_ff <= bad_now ? '0 : doy_now;
      end
      if (cmd.step) begin
         count_ff <= count_ff - 1'b1;
         if (day_ff >= cur_len) begin
            day_ff <= DayFirst;
            if (month_ff == MonthDec) begin
               month_ff <= MonthJan;
               // The century counters follow the year so the leap rule needs no divide.
               if (year_ff == YearMax) begin
                  year_ff <= '0;
                  rem_ff  <= '0;
                  quo_ff  <= '0;
               end else begin
                  year_ff <= year_ff + 1'b1;
                  if (rem_ff == CenturyLast) begin
                     rem_ff <= '0;
                     quo_ff <= quo_ff + 1'b1;
                  end else begin
                     rem_ff <= rem_ff + 1'b1;
                  end
               end
            end else begin
               month_ff <= month_ff + 1'b1;
            end
         end else begin
            day_ff <= day_ff + 1'b1;
         end
      end
      if (cmd.push) begin
         out_ff.day_of_year <= doy_ff;
         out_ff.end_year    <= year_ff;
         out_ff.end_month   <= month_ff;
         out_ff.end_day     <= day_ff;
         out_ff.bad_date    <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)         out_valid_ff <= 1'b0;
      else if (cmd.push) out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp             = out_ff;
   assign status.n_zero   = (count_ff == '0);
   assign status.n_one    = (count_ff == CountWidth'(1));
   assign status.bad_date = bad_now;
   assign status.out_free = !out_valid_ff || rsp_ready;

`ifndef ASSERT_OFF
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (rem_ff < Century))
      else $error("century remainder out of range while stepping");
   a_good_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.bad_date) |->
         (rsp.end_day != '0 && rsp.end_month != '0 && rsp.end_month <= MonthDec))
      else $error("valid response carries an impossible date");
`endif

endmodule

// ===== src/gregorian_date_add_days.sv =====
// Usage
//   Request beat (req_chan): start_year, start_month, start_day, days_to_add.
//   Response beat (rsp_chan): day_of_year, end_year, end_month, end_day, bad_date.
//   Both channels move a beat when valid and ready are high at a rising edge.
// Timing
//   One request is in work at a time. An accepted request goes through the
//   year split (divide, then remainder), the date check and the day steps,
//   then its response is pushed; the steps are skipped when days_to_add is
//   zero or the date is bad. The day-stepping sequencer advances one calendar
//   day per cycle.
//   The response sits in an output register; the next request is accepted in
//   the cycle after the previous result has moved into it.
// Stall
//   If the receiver holds rsp_chan.ready low, the response holds steady; a
//   second finished result waits in the sequencer until the register frees.
// Reset
//   Synchronous, active high: the sequencer returns to idle and no response is
//   valid. The block is ready for a request in the first cycle after reset.
// Depends on gda_pkg, gda_if, gda_ctrl and gda_dpath.
module gregorian_date_add_days import gda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gda_req_if.sink   req_chan,
   gda_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   req_type    req_data;
   rsp_type    rsp_data;
   logic       rsp_valid;

   assign req_data.start_year  = req_chan.start_year;
   assign req_data.start_month = req_chan.start_month;
   assign req_data.start_day   = req_chan.start_day;
   assign req_data.days_to_add = req_chan.days_to_add;

   gda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gda_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp_data)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.day_of_year = rsp_data.day_of_year;
   assign rsp_chan.end_year    = rsp_data.end_year;
   assign rsp_chan.end_month   = rsp_data.end_month;
   assign rsp_chan.end_day     = rsp_data.end_day;
   assign rsp_chan.bad_date    = rsp_data.bad_date;

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for gregorian_date_add_days: directed date table, then random dates.
// Expected results come from the table where it gives them, else from a day-stepping calendar predictor in this module.
// Depends on gda_pkg, gda_if and the block itself.
module tb;
   import gda_pkg::*;

   localparam int unsigned QuietLimit  = 300000;
   localparam int unsigned RandomItems = 75;
   localparam int unsigned CalmItems   = 20;
   localparam int unsigned PauseItem   = 40;
   localparam int unsigned DrainCycles = 12;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type want;
   } date_case_type;

   logic clock = 1'b0;
   logic reset;

   gda_req_if req_chan ();
   gda_rsp_if rsp_chan ();

   gregorian_date_add_days u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_case_type calendar_rows[$];
   rsp_type       expected_dates[$];
   rsp_type       oldest_date;
   int unsigned   mismatches = 0;
   int unsigned   quiet_cycles;
   int unsigned   stall_left;
   bit            idling_on;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit leap_rule(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_rule(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Ordinal day of the start date, and the date days_to_add days on.
   function automatic rsp_type advance_date(req_type r);
      rsp_type     o;
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned n;
      int unsigned doy;
      int unsigned k;
      bit          bad;
      y   = r.start_year;
      m   = r.start_month;
      d   = r.start_day;
      n   = r.days_to_add;
      doy = 0;
      bad = (m < 1) || (m > 12) || (d == 0) || (d > month_days(y, m));
      if (!bad) begin
         for (k = 1; k < m; k++)
            doy += month_days(y, k);
         doy += d;
         while (n > 0) begin
            n--;
            d++;
            if (d > month_days(y, m)) begin
               d = 1;
               m++;
               if (m == 13) begin
                  m = 1;
                  y = (y + 1) & 32'h3FFF;
               end
            end
         end
      end
      o.day_of_year = doy[DoyWidth-1:0];
      o.end_year    = y[YearWidth-1:0];
      o.end_month   = m[MonthWidth-1:0];
      o.end_day     = d[DayWidth-1:0];
      o.bad_date    = bad;
      return o;
   endfunction

   task automatic add_row(int unsigned y, m, d, n, bit known = 0, int unsigned doy = 0,
                          ey = 0, em = 0, ed = 0, bit bad = 0);
      date_case_type c;
      c.req           = '{y[YearWidth-1:0], m[MonthWidth-1:0], d[DayWidth-1:0],
                          n[CountWidth-1:0]};
      c.known         = known;
      c.want.day_of_year = doy[DoyWidth-1:0];
      c.want.end_year    = ey[YearWidth-1:0];
      c.want.end_month   = em[MonthWidth-1:0];
      c.want.end_day     = ed[DayWidth-1:0];
      c.want.bad_date    = bad;
      calendar_rows.push_back(c);
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Drives one request beat and records its expected response once accepted.
   task automatic send_date(req_type r, bit known, rsp_type want);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.start_year  <= r.start_year;
      req_chan.start_month <= r.start_month;
      req_chan.start_day   <= r.start_day;
      req_chan.days_to_add <= r.days_to_add;
      do @(posedge clock); while (!req_chan.ready);
      expected_dates.push_back(known ? want : advance_date(r));
   endtask

   function automatic req_type random_date();
      req_type     r;
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned len;
      int unsigned pick;
      if ($urandom_range(0, 3) == 0)
         y = $urandom_range(0, 163) * 100;
      else
         y = $urandom_range(0, 16383);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         if (pick < 4) begin
            m = $urandom_range(13, 16) % 16;
            d = $urandom_range(0, 31);
         end else begin
            m   = $urandom_range(1, 12);
            len = month_days(y, m);
            d   = (len == 31 || pick < 6) ? 0 : $urandom_range(len + 1, 31);
         end
      end else begin
         m = $urandom_range(1, 12);
         d = ($urandom_range(0, 3) == 0) ? month_days(y, m)
                                         : $urandom_range(1, month_days(y, m));
      end
      r.start_year  = y[YearWidth-1:0];
      r.start_month = m[MonthWidth-1:0];
      r.start_day   = d[DayWidth-1:0];
      // Long advances cost one cycle per day, so only a few of them.
      pick = $urandom_range(0, 99);
      if (pick < 4)
         r.days_to_add = $urandom_range(0, 65535);
      else if (pick < 20)
         r.days_to_add = $urandom_range(0, 3);
      else
         r.days_to_add = $urandom_range(0, 1500);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_dates.size() == 0) begin
               report_mismatch("unexpected response, day_of_year", rsp_chan.day_of_year, 0);
            end else begin
               oldest_date = expected_dates.pop_front();
               if (rsp_chan.day_of_year !== oldest_date.day_of_year)
                  report_mismatch("day_of_year", rsp_chan.day_of_year,
                                  oldest_date.day_of_year);
               if (rsp_chan.end_year !== oldest_date.end_year)
                  report_mismatch("end_year", rsp_chan.end_year, oldest_date.end_year);
               if (rsp_chan.end_month !== oldest_date.end_month)
                  report_mismatch("end_month", rsp_chan.end_month, oldest_date.end_month);
               if (rsp_chan.end_day !== oldest_date.end_day)
                  report_mismatch("end_day", rsp_chan.end_day, oldest_date.end_day);
               if (rsp_chan.bad_date !== oldest_date.bad_date)
                  report_mismatch("bad_date", rsp_chan.bad_date, oldest_date.bad_date);
            end
         end
         if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left     <= $urandom_range(0, 6);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("gregorian_date_add_days test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_type none;
      int unsigned i;
      none                 = '0;
      reset                = 1'b1;
      idling_on            = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.start_year  = '0;
      req_chan.start_month = '0;
      req_chan.start_day   = '0;
      req_chan.days_to_add = '0;

      // Results are spelled out where the calendar makes them obvious.
      add_row(2000, 1, 1, 0, 1, 1, 2000, 1, 1, 0);
      add_row(2023, 12, 31, 1, 1, 365, 2024, 1, 1, 0);
      add_row(2024, 12, 31, 1, 1, 366, 2025, 1, 1, 0);
      add_row(16383, 12, 31, 1, 1, 365, 0, 1, 1, 0);
      add_row(2024, 2, 29, 0, 1, 60, 2024, 2, 29, 0);
      add_row(2000, 2, 29, 0, 1, 60, 2000, 2, 29, 0);
      add_row(2023, 1, 31, 0, 1, 31, 2023, 1, 31, 0);
      add_row(2400, 12, 31, 0, 1, 366, 2400, 12, 31, 0);
      add_row(2023, 2, 29, 7, 1, 0, 2023, 2, 29, 1);
      add_row(1900, 2, 29, 3, 1, 0, 1900, 2, 29, 1);
      add_row(2000, 0, 15, 5, 1, 0, 2000, 0, 15, 1);
      add_row(2000, 13, 1, 1, 1, 0, 2000, 13, 1, 1);
      add_row(2000, 15, 10, 2, 1, 0, 2000, 15, 10, 1);
      add_row(2000, 6, 0, 4, 1, 0, 2000, 6, 0, 1);
      add_row(2023, 4, 31, 9, 1, 0, 2023, 4, 31, 1);
      add_row(16383, 15, 31, 65535, 1, 0, 16383, 15, 31, 1);
      add_row(0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
      add_row(0, 2, 29, 365);
      add_row(2023, 1, 31, 1);
      add_row(2024, 2, 28, 1);
      add_row(2023, 2, 28, 1);
      add_row(2100, 2, 28, 1);
      add_row(2100, 3, 1, 0);
      add_row(9999, 12, 31, 65535);
      add_row(16383, 6, 15, 65535);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (calendar_rows[k])
         send_date(calendar_rows[k].req, calendar_rows[k].known, calendar_rows[k].want);

      for (i = 0; i < RandomItems; i++) begin
         if (i == PauseItem) begin
            req_chan.valid <= 1'b0;
            while (expected_dates.size() != 0) @(posedge clock);
         end
         if (i == RandomItems - CalmItems)
            idling_on = 1'b0;
         send_date(random_date(), 1'b0, none);
      end
      req_chan.valid <= 1'b0;

      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("gregorian_date_add_days test passed");
      else
         $display("gregorian_date_add_days test failed");
      $finish;
   end

endmodule

// ===== gregorian_date_add_days.f =====
src/gda_pkg.sv
src/gda_if.sv
src/gda_ctrl.sv
src/gda_dpath.sv
src/gregorian_date_add_days.sv
sim/tb.sv
